FILE: hw/rtl/lobm_pkg.sv
// Shared types and codes for the limit order book matcher.
package lobm_pkg;

  localparam int unsigned OrderSlotsDef = 32;

  localparam logic CMD_PLACE   = 1'b0;
  localparam logic CMD_CANCEL  = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic SIDE_SELL   = 1'b1;
  localparam logic KIND_LIMIT  = 1'b0;
  localparam logic KIND_MARKET = 1'b1;
  localparam logic ITEM_TRADE  = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_FILLED    = 3'd0,
    ST_RESTED    = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_FILL,
    S_STATUS
  } state_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] order_id;
    logic        side;
    logic        order_kind;
    logic [31:0] limit_price;
    logic [31:0] order_volume;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [31:0] price;
    logic [31:0] volume;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    clr;
    logic    rd;
    logic    fill;
    logic    emit;
    status_e code;
    logic    rest;
    logic    cancel;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_cancel;
    logic mkt;
    logic rem_zero;
    logic best_found;
    logic fill_last;
    logic free_found;
    logic out_free;
    logic scan_last;
  } dp_sts_t;

endpackage

FILE: hw/rtl/limit_order_book_matcher.sv
// Each fill pass runs through start, one registered pool read per slot, drain, decide and
// fill; a place with volume left after its fills scans once more; the status item follows.
// A zero volume place goes from start straight to status; a cancel scans once, then emits
// its status; output stalls hold the fill and status steps.
// Throughput: one command at a time; the next is accepted the cycle after its status.
// Reset (rst_ni low, asynchronous): pool empty (memories kept), arrival counter zero.
module limit_order_book_matcher #(
  parameter int unsigned ORDER_SLOTS = lobm_pkg::OrderSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lobm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lobm_pkg::out_item_t out_item_o
);
  import lobm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: load, scan, fill loop, status
  lobm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: pool storage, best-order search, trade arithmetic, output register
  lobm_dp #(
    .ORDER_SLOTS (ORDER_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: hw/rtl/lobm_dp.sv
// Datapath: order pool memories, scan compare, fill arithmetic, output register.
module lobm_dp #(
  parameter int unsigned ORDER_SLOTS = lobm_pkg::OrderSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lobm_pkg::in_item_t  in_item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output lobm_pkg::out_item_t out_item_o,
  input  lobm_pkg::dp_cmd_t   cmd_i,
  output lobm_pkg::dp_sts_t   sts_o
);
  import lobm_pkg::*;

  localparam int unsigned IW = $clog2(ORDER_SLOTS);

  logic [31:0] mem_ident [ORDER_SLOTS];
  logic        mem_side  [ORDER_SLOTS];
  logic [31:0] mem_price [ORDER_SLOTS];
  logic [31:0] mem_rem   [ORDER_SLOTS];
  logic [31:0] mem_arr   [ORDER_SLOTS];

  logic [ORDER_SLOTS-1:0] valid_q, valid_d;
  in_item_t    item_q;
  logic [31:0] rem_q, rem_d;
  logic [31:0] cnt_q;

  logic [IW-1:0] addr_q;
  logic          rd_ok_q;
  logic [IW-1:0] rd_idx_q;
  logic [31:0]   rd_ident_q, rd_price_q, rd_rem_q, rd_arr_q;
  logic          rd_side_q;

  logic          best_found_q;
  logic [IW-1:0] best_idx_q;
  logic [31:0]   best_ident_q, best_price_q, best_rem_q, best_age_q;

  logic          out_valid_q;
  out_item_t     out_q;

  logic          hit, price_ok, better;
  logic [31:0]   age, tv;
  logic [IW-1:0] free_idx;
  logic          free_found;
  logic          out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign age      = cnt_q - rd_arr_q;
  assign tv       = (rem_q < best_rem_q) ? rem_q : best_rem_q;

  always_comb begin
    price_ok = 1'b1;
    if (item_q.order_kind == KIND_LIMIT) begin
      price_ok = (item_q.side == SIDE_BUY) ? (rd_price_q <= item_q.limit_price)
                                           : (rd_price_q >= item_q.limit_price);
    end
    if (rd_price_q != best_price_q) begin
      better = (item_q.side == SIDE_BUY) ? (rd_price_q < best_price_q)
                                         : (rd_price_q > best_price_q);
    end else begin
      better = age > best_age_q;
    end
    if (item_q.cmd == CMD_CANCEL) begin
      hit = rd_ok_q && valid_q[rd_idx_q] && (rd_ident_q == item_q.order_id)
            && !best_found_q;
    end else begin
      hit = rd_ok_q && valid_q[rd_idx_q] && (rd_side_q != item_q.side) && price_ok
            && (!best_found_q || better);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx   = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.fill && (best_rem_q == tv)) valid_d[best_idx_q] = 1'b0;
    if (cmd_i.cancel) valid_d[best_idx_q] = 1'b0;
    if (cmd_i.rest) valid_d[free_idx] = 1'b1;
  end

  always_comb begin
    rem_d = rem_q;
    if (cmd_i.load) rem_d = in_item_i.order_volume;
    else if (cmd_i.fill) rem_d = rem_q - tv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      cnt_q        <= '0;
      addr_q       <= '0;
      rd_ok_q      <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rd_ok_q <= cmd_i.rd;
      if (cmd_i.rest) cnt_q <= cnt_q + 32'd1;
      if (cmd_i.clr) begin
        addr_q       <= '0;
        best_found_q <= 1'b0;
      end else begin
        if (cmd_i.rd) addr_q <= addr_q + IW'(1);
        if (hit) best_found_q <= 1'b1;
      end
      if (cmd_i.fill || cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    rem_q <= rem_d;
    if (cmd_i.rd) begin
      rd_idx_q   <= addr_q;
      rd_ident_q <= mem_ident[addr_q];
      rd_side_q  <= mem_side[addr_q];
      rd_price_q <= mem_price[addr_q];
      rd_rem_q   <= mem_rem[addr_q];
      rd_arr_q   <= mem_arr[addr_q];
    end
    if (hit && !cmd_i.clr) begin
      best_idx_q   <= rd_idx_q;
      best_ident_q <= rd_ident_q;
      best_price_q <= rd_price_q;
      best_rem_q   <= rd_rem_q;
      best_age_q   <= age;
    end
    if (cmd_i.rest) begin
      mem_ident[free_idx] <= item_q.order_id;
      mem_side[free_idx]  <= item_q.side;
      mem_price[free_idx] <= item_q.limit_price;
      mem_rem[free_idx]   <= rem_q;
      mem_arr[free_idx]   <= cnt_q;
    end else if (cmd_i.fill) begin
      mem_rem[best_idx_q] <= best_rem_q - tv;
    end
    if (cmd_i.fill) begin
      out_q.item_kind <= ITEM_TRADE;
      out_q.buy_id    <= (item_q.side == SIDE_BUY) ? item_q.order_id : best_ident_q;
      out_q.sell_id   <= (item_q.side == SIDE_BUY) ? best_ident_q : item_q.order_id;
      out_q.price     <= best_price_q;
      out_q.volume    <= tv;
      out_q.status    <= '0;
      out_q.last      <= 1'b0;
    end else if (cmd_i.emit) begin
      out_q.item_kind <= ITEM_STATUS;
      out_q.buy_id    <= '0;
      out_q.sell_id   <= '0;
      out_q.price     <= '0;
      out_q.volume    <= '0;
      out_q.status    <= cmd_i.code;
      out_q.last      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sts_o.is_cancel  = (item_q.cmd == CMD_CANCEL);
  assign sts_o.mkt        = (item_q.order_kind == KIND_MARKET);
  assign sts_o.rem_zero   = (rem_q == 32'd0);
  assign sts_o.best_found = best_found_q;
  assign sts_o.fill_last  = (rem_q <= best_rem_q);
  assign sts_o.free_found = free_found;
  assign sts_o.out_free   = out_free;
  assign sts_o.scan_last  = (addr_q == IW'(ORDER_SLOTS - 1));

  a_fill_leaves_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |=> (rem_q == $past(rem_q) - $past(tv)))
    else $error("remaining volume not reduced by trade volume");
  a_rest_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rest |=> valid_q[$past(free_idx)])
    else $error("rested order slot not marked valid");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("output register overwritten while stalled");

endmodule

FILE: hw/rtl/lobm_ctrl.sv
// Controller state machine: sequences scans, fills and the status item.
module lobm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lobm_pkg::dp_sts_t sts_i,
  output lobm_pkg::dp_cmd_t cmd_o
);
  import lobm_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_START;
      S_START:    state_d = (!sts_i.is_cancel && sts_i.rem_zero) ? S_STATUS : S_SCAN;
      S_SCAN:     if (sts_i.scan_last) state_d = S_SCAN_END;
      S_SCAN_END: state_d = S_DECIDE;
      S_DECIDE:   state_d = (!sts_i.is_cancel && sts_i.best_found) ? S_FILL : S_STATUS;
      S_FILL: begin
        if (sts_i.out_free) state_d = sts_i.fill_last ? S_STATUS : S_START;
      end
      S_STATUS:   if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.code = ST_FILLED;
    in_stall_o = (state_q != S_IDLE);
    if (sts_i.is_cancel) begin
      cmd_o.code = sts_i.best_found ? ST_CANCELLED : ST_NOT_FOUND;
    end else if (sts_i.rem_zero) begin
      cmd_o.code = ST_FILLED;
    end else if (sts_i.mkt) begin
      cmd_o.code = ST_DROPPED;
    end else begin
      cmd_o.code = sts_i.free_found ? ST_RESTED : ST_REJECTED;
    end
    case (state_q)
      S_IDLE:  cmd_o.load = in_valid_i;
      S_START: cmd_o.clr = 1'b1;
      S_SCAN:  cmd_o.rd = 1'b1;
      S_FILL:  cmd_o.fill = sts_i.out_free;
      S_STATUS: begin
        cmd_o.emit   = sts_i.out_free;
        cmd_o.rest   = sts_i.out_free && !sts_i.is_cancel && !sts_i.rem_zero
                       && !sts_i.mkt && sts_i.free_found;
        cmd_o.cancel = sts_i.out_free && sts_i.is_cancel && sts_i.best_found;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  a_fill_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fill |-> sts_i.best_found)
    else $error("fill without a matching resting order");
  a_rest_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rest |-> sts_i.free_found)
    else $error("rest without a free slot");
  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == S_IDLE))
    else $error("status item did not end the run");

endmodule

FILE: sim/lobm_checker.sv
// Checker for the limit order book matcher: watches both channels, predicts trades, compares.
module lobm_checker #(
  parameter int unsigned ORDER_SLOTS = lobm_pkg::OrderSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  lobm_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  lobm_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  localparam int ExpDepth = 64;

  logic        book_used [ORDER_SLOTS];
  logic [31:0] book_id   [ORDER_SLOTS];
  logic        book_side [ORDER_SLOTS];
  logic [31:0] book_price[ORDER_SLOTS];
  logic [31:0] book_left [ORDER_SLOTS];
  logic [31:0] book_stamp[ORDER_SLOTS];
  logic [31:0] stamp_ctr;

  // expected items, ring indexed by running write and read counts
  out_item_t exp_items [ExpDepth];
  int        exp_wr = 0;
  int        exp_rd = 0;

  assign pending_o = exp_wr - exp_rd;

  function automatic void queue_item(out_item_t r);
    exp_items[exp_wr % ExpDepth] = r;
    exp_wr++;
  endfunction

  function automatic out_item_t status_rec(status_e code);
    out_item_t r;
    r = '0;
    r.item_kind = ITEM_STATUS;
    r.status    = code;
    r.last      = 1'b1;
    return r;
  endfunction

  // Price first, then larger age; ties keep the lower index.
  function automatic bit outranks(int a, int b, logic side);
    logic [31:0] age_a, age_b;
    if (book_price[a] != book_price[b])
      return (side == SIDE_BUY) ? (book_price[a] < book_price[b])
                                : (book_price[a] > book_price[b]);
    age_a = stamp_ctr - book_stamp[a];
    age_b = stamp_ctr - book_stamp[b];
    return age_a > age_b;
  endfunction

  task automatic match_order(in_item_t it);
    logic [31:0] left, tv;
    int best, free_slot;
    bit ok;
    out_item_t r;
    if (it.cmd == CMD_CANCEL) begin
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        if (book_used[i] && book_id[i] == it.order_id) begin
          book_used[i] = 1'b0;
          queue_item(status_rec(ST_CANCELLED));
          return;
        end
      end
      queue_item(status_rec(ST_NOT_FOUND));
      return;
    end
    left = it.order_volume;
    while (left != 0) begin
      best = -1;
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        if (!book_used[i] || book_side[i] == it.side) continue;
        if (it.order_kind == KIND_MARKET) ok = 1;
        else if (it.side == SIDE_BUY) ok = book_price[i] <= it.limit_price;
        else ok = book_price[i] >= it.limit_price;
        if (!ok) continue;
        if (best < 0 || outranks(i, best, it.side)) best = i;
      end
      if (best < 0) break;
      tv = (left < book_left[best]) ? left : book_left[best];
      r = '0;
      r.item_kind = ITEM_TRADE;
      r.buy_id    = (it.side == SIDE_BUY) ? it.order_id : book_id[best];
      r.sell_id   = (it.side == SIDE_BUY) ? book_id[best] : it.order_id;
      r.price     = book_price[best];
      r.volume    = tv;
      queue_item(r);
      left -= tv;
      book_left[best] -= tv;
      if (book_left[best] == 0) book_used[best] = 1'b0;
    end
    if (left == 0) queue_item(status_rec(ST_FILLED));
    else if (it.order_kind == KIND_MARKET) queue_item(status_rec(ST_DROPPED));
    else begin
      free_slot = -1;
      for (int i = 0; i < ORDER_SLOTS; i++)
        if (!book_used[i]) begin
          free_slot = i;
          break;
        end
      if (free_slot < 0) queue_item(status_rec(ST_REJECTED));
      else begin
        book_used[free_slot]  = 1'b1;
        book_id[free_slot]    = it.order_id;
        book_side[free_slot]  = it.side;
        book_price[free_slot] = it.limit_price;
        book_left[free_slot]  = left;
        book_stamp[free_slot] = stamp_ctr;
        stamp_ctr++;
        queue_item(status_rec(ST_RESTED));
      end
    end
  endtask

  task automatic compare_item(out_item_t got);
    out_item_t w;
    if (exp_wr == exp_rd) begin
      $error("unexpected item %h", got);
      fail_count_o++;
      return;
    end
    w = exp_items[exp_rd % ExpDepth];
    exp_rd++;
    if (got.item_kind != w.item_kind) begin
      $error("item_kind exp %0d got %0d", w.item_kind, got.item_kind); fail_count_o++;
    end
    if (got.buy_id != w.buy_id) begin
      $error("buy_id exp %0d got %0d", w.buy_id, got.buy_id); fail_count_o++;
    end
    if (got.sell_id != w.sell_id) begin
      $error("sell_id exp %0d got %0d", w.sell_id, got.sell_id); fail_count_o++;
    end
    if (got.price != w.price) begin
      $error("price exp %0d got %0d", w.price, got.price); fail_count_o++;
    end
    if (got.volume != w.volume) begin
      $error("volume exp %0d got %0d", w.volume, got.volume);
      fail_count_o++;
    end
    if (got.status != w.status) begin
      $error("status exp %0d got %0d", w.status, got.status); fail_count_o++;
    end
    if (got.last != w.last) begin
      $error("last exp %0d got %0d", w.last, got.last); fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    stamp_ctr = '0;
    for (int i = 0; i < ORDER_SLOTS; i++) book_used[i] = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) compare_item(out_item_i);
      if (in_valid_i && !in_stall_i) match_order(in_item_i);
    end
  end
endmodule

FILE: sim/limit_order_book_matcher_tb.sv
// Testbench top for the limit order book matcher: stimulus, stalls and verdict.
module limit_order_book_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  localparam int unsigned Slots = lobm_pkg::OrderSlotsDef;
  localparam int RandItems = 114;
  localparam longint CycleLimit = 2000000;
  localparam int IdDepth = 256;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  // Idle percentages per phase; the drive loops read them.
  int        send_idle_pct = 31;
  int        recv_idle_pct = 57;
  bit        hold_off = 1'b0;   // long receiver hold-off under pressure
  longint    cycle_ctr = 0;
  logic [31:0] next_id = 32'd1;
  logic [31:0] placed_ids [IdDepth];
  int        n_placed = 0;

  always #2 clk_i = ~clk_i;

  limit_order_book_matcher #(.ORDER_SLOTS(Slots)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  lobm_checker #(.ORDER_SLOTS(Slots)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver: random stall, forced high during a hold-off.
  always @(posedge clk_i) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_ctr <= cycle_ctr + 1;
    if (cycle_ctr > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item and hold it until accepted; random gaps before it.
  // Valid stays up after the accept edge until the next call or the end drives it.
  task automatic send_order(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  function automatic in_item_t make_place(logic side, logic kind, logic [31:0] price,
                                          logic [31:0] vol);
    in_item_t it;
    it = '0;
    it.cmd          = CMD_PLACE;
    it.order_id     = next_id;
    it.side         = side;
    it.order_kind   = kind;
    it.limit_price  = price;
    it.order_volume = vol;
    return it;
  endfunction

  task automatic place(logic side, logic kind, logic [31:0] price, logic [31:0] vol);
    send_order(make_place(side, kind, price, vol));
    if (n_placed < IdDepth) begin
      placed_ids[n_placed] = next_id;
      n_placed++;
    end
    next_id++;
  endtask

  task automatic cancel(logic [31:0] id);
    in_item_t it;
    it = '0;
    it.cmd         = CMD_CANCEL;
    it.order_id    = id;
    it.side        = 1'($urandom_range(1));
    it.order_kind  = 1'($urandom_range(1));
    it.limit_price = $urandom;
    it.order_volume = $urandom;
    send_order(it);
  endtask

  // Random command mix around a narrow price band so books cross often.
  task automatic random_command();
    int pick;
    logic [31:0] vol, price;
    pick = $urandom_range(99);
    price = 32'd1000 + $urandom_range(20);
    case ($urandom_range(9))
      0: vol = 32'hFFFF_FFFF - $urandom_range(3);
      1: vol = '0;
      default: vol = $urandom_range(1, 50);
    endcase
    if (pick < 12 && n_placed > 0)
      cancel(placed_ids[$urandom_range(n_placed - 1)]);
    else if (pick < 16)
      cancel($urandom);
    else if (pick < 20)
      place(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom);
    else if (pick < 30)
      place(1'($urandom_range(1)), KIND_MARKET, $urandom, vol);
    else
      place(1'($urandom_range(1)), KIND_LIMIT, price, vol);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every command, zero volume, market, ties, not found.
    place(SIDE_BUY, KIND_LIMIT, 32'd0, 32'd0);               // zero volume fills
    place(SIDE_SELL, KIND_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // sell at max price
    place(SIDE_SELL, KIND_LIMIT, 32'd100, 32'd5);
    place(SIDE_SELL, KIND_LIMIT, 32'd100, 32'd7);            // same price, younger
    place(SIDE_SELL, KIND_LIMIT, 32'd90, 32'd3);
    place(SIDE_BUY, KIND_LIMIT, 32'd100, 32'd10);            // takes 90, then oldest 100, then younger 100
    place(SIDE_BUY, KIND_MARKET, 32'd0, 32'd20);             // sweeps incl. max price
    place(SIDE_BUY, KIND_LIMIT, 32'd50, 32'd4);
    place(SIDE_SELL, KIND_MARKET, 32'hFFFF_FFFF, 32'd9);     // market remainder dropped
    cancel(32'hDEAD_BEEF);                                   // not found
    place(SIDE_BUY, KIND_LIMIT, 32'd55, 32'd6);
    cancel(next_id - 1);                                     // cancelled
    cancel(32'd0);
    cancel(32'hFFFF_FFFF);
    // Fill the pool with buys beside the resting sell; the last of them and one more are rejected.
    for (int i = 0; i < Slots; i++) place(SIDE_BUY, KIND_LIMIT, 32'd10 + i, 32'd1);
    place(SIDE_BUY, KIND_LIMIT, 32'd5, 32'd1);
    place(SIDE_SELL, KIND_MARKET, 32'd0, 32'hFFFF_FFFF);     // clears the buys, many trades

    // Pressure: receiver holds off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) random_command();
    join

    for (int i = 0; i < RandItems / 3; i++) random_command();
    send_idle_pct = 57;
    recv_idle_pct = 31;
    for (int i = 0; i < RandItems / 3; i++) random_command();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < RandItems / 3; i++) random_command();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (4 * Slots + 20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_dp.sv
hw/rtl/lobm_ctrl.sv
hw/rtl/limit_order_book_matcher.sv
sim/lobm_checker.sv
sim/limit_order_book_matcher_tb.sv
